### design/rrso_pkg.sv
package rrso_pkg;

	localparam int STAMP_W = 64;
	localparam int ID_W    = 6;
	localparam int CNT_W   = 7;

	typedef enum logic [2:0] {
		REQ_ENQUEUE = 3'd0,
		REQ_TAKE    = 3'd1,
		REQ_FORGET  = 3'd2,
		REQ_CLEAR   = 3'd3,
		REQ_QUERY   = 3'd4
	} req_type_t;

	// register index, taken from paddr[3] (registers sit 8 bytes apart)
	localparam logic ADDR_REGION_COUNT = 1'b0;
	localparam logic ADDR_STARVE_LIMIT = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, start search
		logic scan;      // step the search over one region
		logic commit;    // apply the request and build the result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
	} dp_sts_t;

endpackage

### design/rrso_datapath.sv
module rrso_datapath #(
	parameter int MAX_REGIONS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrso_pkg::dp_cmd_t             cmd,
	output rrso_pkg::dp_sts_t             sts,
	input  logic [2:0]                    req_type,
	input  logic [rrso_pkg::ID_W-1:0]     region,
	input  logic [rrso_pkg::ID_W-1:0]     cursor,
	input  logic [rrso_pkg::STAMP_W-1:0]  now_time,
	input  logic [rrso_pkg::CNT_W-1:0]    region_count,
	input  logic [rrso_pkg::STAMP_W-1:0]  starvation_limit,
	output logic                          ok,
	output logic [rrso_pkg::ID_W-1:0]     granted_region,
	output logic [rrso_pkg::CNT_W-1:0]    pending_count,
	output logic                          region_pending,
	output logic [rrso_pkg::STAMP_W-1:0]  region_stamp
);
	localparam int IW  = (MAX_REGIONS > 2) ? $clog2(MAX_REGIONS) : 1;
	localparam int NW  = $clog2(MAX_REGIONS + 1);
	localparam int SW  = rrso_pkg::STAMP_W;
	localparam int SMW = (NW > rrso_pkg::ID_W + 1) ? NW : rrso_pkg::ID_W + 1;

	logic [MAX_REGIONS-1:0] pend_q;
	logic [MAX_REGIONS-1:0] stamp_vld_q;
	logic [SW-1:0]          stamp_mem [MAX_REGIONS];
	logic [rrso_pkg::CNT_W-1:0] total_q;

	logic [2:0]    req_q;
	logic [IW-1:0] reg_q;
	logic          reg_ok_q;
	logic [SW-1:0] now_q;
	logic [NW-1:0] n_q;
	logic [IW-1:0] scan_q;
	logic [NW-1:0] step_q;
	logic [SMW-1:0] start_q;

	logic          scan_vld_s1;
	logic [IW-1:0] scan_id_s1;
	logic          scan_pend_s1;
	logic          scan_svld_s1;
	logic [SW-1:0] scan_mem_s1;

	logic          old_found_q;
	logic [IW-1:0] old_id_q;
	logic [SW-1:0] old_stamp_q;
	logic          rr_found_q;
	logic [IW-1:0] rr_id_q;

	logic [SW-1:0] rd_stamp_q;

	logic [NW-1:0]  n_eff;
	logic [SMW-1:0] start_init;
	logic [SMW-1:0] start_red;
	logic           start_ok;
	logic           scan_adv;
	logic [SW-1:0]  scan_stamp;
	logic [SW-1:0]  reg_stamp;
	logic           fire;
	logic [SW-1:0]  age;
	logic [IW-1:0]  grant_id;
	logic           grant_ok;

	always_comb begin
		if (region_count == '0)
			n_eff = NW'(1);
		else if ({{(32-rrso_pkg::CNT_W){1'b0}}, region_count} > 32'(MAX_REGIONS))
			n_eff = NW'(MAX_REGIONS);
		else
			n_eff = NW'(region_count);
	end

	// round robin start is (cursor+1) mod n: subtract n until below it before scanning
	assign start_init = SMW'(cursor) + SMW'(1);
	assign start_red  = start_q - SMW'(n_q);
	assign start_ok   = (start_q < SMW'(n_q));
	assign scan_adv   = cmd.scan && start_ok && (step_q != n_q);

	assign scan_stamp = scan_svld_s1 ? scan_mem_s1 : '0;
	assign reg_stamp  = stamp_vld_q[reg_q] ? rd_stamp_q : '0;
	assign sts.scan_done = (step_q == n_q) && !scan_vld_s1;

	assign age  = now_q - old_stamp_q;
	assign fire = (starvation_limit != '0) && old_found_q &&
	              (now_q >= old_stamp_q) && (age >= starvation_limit);
	assign grant_id = fire ? old_id_q : rr_id_q;
	assign grant_ok = (total_q != '0) && (fire || rr_found_q);

	always_ff @(posedge clk) begin
		if (cmd.load)
			rd_stamp_q <= stamp_mem[IW'(region)];
		scan_mem_s1 <= stamp_mem[scan_q];
		if (cmd.commit) begin
			if (req_q == rrso_pkg::REQ_ENQUEUE && reg_ok_q && !pend_q[reg_q] &&
			    reg_stamp == '0)
				stamp_mem[reg_q] <= (now_q != '0) ? now_q : SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q         <= '0;
			stamp_vld_q    <= '0;
			total_q        <= '0;
			req_q          <= '0;
			reg_q          <= '0;
			reg_ok_q       <= 1'b0;
			now_q          <= '0;
			n_q            <= '0;
			scan_q         <= '0;
			step_q         <= '0;
			start_q        <= '0;
			scan_vld_s1    <= 1'b0;
			scan_id_s1     <= '0;
			scan_pend_s1   <= 1'b0;
			scan_svld_s1   <= 1'b0;
			old_found_q    <= 1'b0;
			old_id_q       <= '0;
			old_stamp_q    <= '0;
			rr_found_q     <= 1'b0;
			rr_id_q        <= '0;
			ok             <= 1'b0;
			granted_region <= '0;
			pending_count  <= '0;
			region_pending <= 1'b0;
			region_stamp   <= '0;
		end else begin
			scan_vld_s1 <= scan_adv;
			if (cmd.load) begin
				req_q       <= req_type;
				reg_q       <= IW'(region);
				reg_ok_q    <= ({{(32-rrso_pkg::ID_W){1'b0}}, region} < 32'(n_eff));
				now_q       <= now_time;
				n_q         <= n_eff;
				start_q     <= start_init;
				scan_q      <= start_init[IW-1:0];
				step_q      <= '0;
				old_found_q <= 1'b0;
				rr_found_q  <= 1'b0;
			end
			if (cmd.scan && !start_ok) begin
				start_q <= start_red;
				scan_q  <= start_red[IW-1:0];
			end
			if (scan_adv) begin
				step_q       <= step_q + NW'(1);
				scan_q       <= (32'(scan_q) + 1 == 32'(n_q)) ? '0 : scan_q + IW'(1);
				scan_id_s1   <= scan_q;
				scan_pend_s1 <= pend_q[scan_q];
				scan_svld_s1 <= stamp_vld_q[scan_q];
			end
			if (scan_vld_s1 && scan_pend_s1) begin
				if (!rr_found_q) begin
					rr_found_q <= 1'b1;
					rr_id_q    <= scan_id_s1;
				end
				// the wrap means ids are not visited in order: break ties to lower id
				if (!old_found_q || scan_stamp < old_stamp_q ||
				    (scan_stamp == old_stamp_q && scan_id_s1 < old_id_q)) begin
					old_found_q <= 1'b1;
					old_id_q    <= scan_id_s1;
					old_stamp_q <= scan_stamp;
				end
			end
			if (cmd.commit) begin
				ok             <= 1'b0;
				granted_region <= '0;
				region_pending <= 1'b0;
				region_stamp   <= '0;
				pending_count  <= total_q;
				case (req_q)
					rrso_pkg::REQ_ENQUEUE: begin
						if (reg_ok_q) begin
							ok <= 1'b1;
							if (!pend_q[reg_q]) begin
								pend_q[reg_q]      <= 1'b1;
								stamp_vld_q[reg_q] <= 1'b1;
								total_q            <= total_q + 1'b1;
								pending_count      <= total_q + 1'b1;
							end
						end
					end
					rrso_pkg::REQ_TAKE: begin
						if (grant_ok) begin
							ok             <= 1'b1;
							granted_region <= rrso_pkg::ID_W'(grant_id);
							pend_q[grant_id] <= 1'b0;
							total_q        <= total_q - 1'b1;
							pending_count  <= total_q - 1'b1;
						end
					end
					rrso_pkg::REQ_FORGET: begin
						if (reg_ok_q) begin
							ok                 <= 1'b1;
							stamp_vld_q[reg_q] <= 1'b0;
							if (pend_q[reg_q]) begin
								pend_q[reg_q] <= 1'b0;
								if (total_q != '0) begin
									total_q       <= total_q - 1'b1;
									pending_count <= total_q - 1'b1;
								end
							end
						end
					end
					rrso_pkg::REQ_CLEAR: begin
						ok            <= 1'b1;
						pend_q        <= '0;
						stamp_vld_q   <= '0;
						total_q       <= '0;
						pending_count <= '0;
					end
					rrso_pkg::REQ_QUERY: begin
						if (reg_ok_q) begin
							ok             <= 1'b1;
							region_pending <= pend_q[reg_q];
							region_stamp   <= reg_stamp;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= MAX_REGIONS) else $error("pending total overflow");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= n_q) else $error("scan ran past region count");
	a_grant_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && req_q == rrso_pkg::REQ_TAKE && grant_ok |-> pend_q[grant_id])
		else $error("grant of idle region");
endmodule

### design/rrso_ctrl.sv
module rrso_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output rrso_pkg::dp_cmd_t cmd,
	input  rrso_pkg::dp_sts_t sts
);
	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT, ST_OUT} state_t;
	state_t state_q;

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = (state_q == ST_OUT);
	assign cmd.load   = s_tvalid && s_tready;
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.commit = (state_q == ST_COMMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:   if (s_tvalid) state_q <= ST_SCAN;
				ST_SCAN:   if (sts.scan_done) state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= ST_OUT;
				ST_OUT:    if (m_tready) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.scan, cmd.commit})) else $error("overlapping commands");
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid) else $error("result not presented");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("accepted while result pending");
endmodule

### design/round_robin_with_starvation_override.sv
// channel | dir | handshake          | payload
// s_axis  | in  | s_tvalid/s_tready  | s_tdata: req_type, region, cursor, now_time
// m_axis  | out | m_tvalid/m_tready  | m_tdata: ok, granted_region, pending_count,
//         |     |                    |          region_pending, region_stamp
// apb     | in  | psel/penable/pready| region_count @0x0, starvation_limit @0x8
// One request at a time: accept, subtract N until cursor+1 is below it (N =
// region count in use), scan the N regions, drain the registered stamp read,
// commit, then the result waits for m_tready. The search over regions is serial.
// Reset clears all pending flags and stamps at once through valid bits.
// A stalled result holds m_tdata and blocks new requests.
module round_robin_with_starvation_override #(
	parameter int MAX_REGIONS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,  // req_type[2:0], region[8:3], cursor[14:9], now_time[78:15]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,  // ok[0], granted_region[6:1], pending_count[13:7],
	                               // region_pending[14], region_stamp[78:15]
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);
	rrso_pkg::dp_cmd_t cmd;
	rrso_pkg::dp_sts_t sts;
	logic [rrso_pkg::CNT_W-1:0]   region_count_q;
	logic [rrso_pkg::STAMP_W-1:0] starve_limit_q;
	logic ok, region_pending;
	logic [5:0] granted_region;
	logic [6:0] pending_count;
	logic [63:0] region_stamp;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= 7'd64;
			starve_limit_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[3] == rrso_pkg::ADDR_REGION_COUNT && paddr[2:0] == 3'b000)
				region_count_q <= pwdata[6:0];
			else if (paddr[3] == rrso_pkg::ADDR_STARVE_LIMIT && paddr[2:0] == 3'b000)
				starve_limit_q <= pwdata;
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == {rrso_pkg::ADDR_REGION_COUNT, 3'b000})
			prdata = {57'd0, region_count_q};
		else if (paddr == {rrso_pkg::ADDR_STARVE_LIMIT, 3'b000})
			prdata = starve_limit_q;
	end

	rrso_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .sts(sts)
	);

	rrso_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(s_tdata[2:0]), .region(s_tdata[8:3]), .cursor(s_tdata[14:9]),
		.now_time(s_tdata[78:15]), .region_count(region_count_q),
		.starvation_limit(starve_limit_q), .ok(ok), .granted_region(granted_region),
		.pending_count(pending_count), .region_pending(region_pending),
		.region_stamp(region_stamp)
	);

	assign m_tdata = {1'b0, region_stamp, region_pending, pending_count, granted_region, ok};
endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int MAXR = 64;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [63:0] now_time;
		logic [5:0]  cursor;
		logic [5:0]  region;
		logic [2:0]  req;
	} request_t;

	typedef struct packed {
		logic [63:0] stamp;
		logic        qpend;
		logic [6:0]  cnt;
		logic [5:0]  granted;
		logic        ok;
	} grant_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [79:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [79:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	round_robin_with_starvation_override dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// scoreboard-side copy of the arbiter state
	logic        pend_flag [MAXR];
	logic [63:0] first_dirty [MAXR];
	logic [6:0]  pend_total;
	logic [6:0]  region_cnt;
	logic [63:0] starve_limit;

	request_t request_q [$];
	grant_t   grant_q [$];
	int errors = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;

	function automatic int active_regions();
		int n;
		n = int'(region_cnt);
		if (n == 0) n = 1;
		if (n > MAXR) n = MAXR;
		return n;
	endfunction

	function automatic grant_t arbitrate(request_t r);
		grant_t g;
		int n, best, sel, id;
		n = active_regions();
		g = '0;
		case (r.req)
			rrso_pkg::REQ_ENQUEUE: if (r.region < n) begin
				g.ok = 1;
				if (!pend_flag[r.region]) begin
					if (first_dirty[r.region] == 0)
						first_dirty[r.region] = (r.now_time != 0) ? r.now_time : 64'd1;
					pend_flag[r.region] = 1;
					pend_total++;
				end
			end
			rrso_pkg::REQ_TAKE: if (pend_total != 0) begin
				sel = n;
				if (starve_limit != 0) begin
					best = n;
					for (int i = 0; i < n; i++)
						if (pend_flag[i] && (best == n || first_dirty[i] < first_dirty[best]))
							best = i;
					if (best < n && r.now_time >= first_dirty[best] &&
					    r.now_time - first_dirty[best] >= starve_limit)
						sel = best;
				end
				if (sel == n)
					for (int i = 0; i < n; i++) begin
						id = (((r.cursor + 1) % n) + i) % n;
						if (pend_flag[id]) begin
							sel = id;
							break;
						end
					end
				if (sel < n) begin
					pend_flag[sel] = 0;
					pend_total--;
					g.ok = 1;
					g.granted = 6'(sel);
				end
			end
			rrso_pkg::REQ_FORGET: if (r.region < n) begin
				g.ok = 1;
				if (pend_flag[r.region]) begin
					pend_flag[r.region] = 0;
					if (pend_total != 0) pend_total--;
				end
				first_dirty[r.region] = 0;
			end
			rrso_pkg::REQ_CLEAR: begin
				for (int i = 0; i < MAXR; i++) begin
					pend_flag[i] = 0;
					first_dirty[i] = 0;
				end
				pend_total = 0;
				g.ok = 1;
			end
			rrso_pkg::REQ_QUERY: if (r.region < n) begin
				g.ok = 1;
				g.qpend = pend_flag[r.region];
				g.stamp = first_dirty[r.region];
			end
			default: ;
		endcase
		g.cnt = pend_total;
		return g;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			grant_q.push_back(arbitrate(s_tdata[78:0]));
			request_q.pop_front();
			send_gap <= pick_gap();
		end
		if ((s_tvalid && s_tready) || !s_tvalid) begin
			if (!arst_n || request_q.size() == 0 || (send_gap > 0 && !s_tvalid)) begin
				s_tvalid <= 0;
				if (send_gap > 0 && !(s_tvalid && s_tready)) send_gap <= send_gap - 1;
			end else if (s_tvalid && s_tready && request_q.size() > 0) begin
				s_tvalid <= 0;
			end else begin
				s_tvalid <= 1;
				s_tdata <= {1'b0, request_q[0]};
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		grant_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[78:0];
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = grant_q.pop_front();
				if (got.ok !== want.ok)
					$display("%0t: ok exp %0d got %0d", $time, want.ok, got.ok);
				if (got.granted !== want.granted)
					$display("%0t: granted exp %0d got %0d", $time, want.granted, got.granted);
				if (got.cnt !== want.cnt)
					$display("%0t: pending_count exp %0d got %0d", $time, want.cnt, got.cnt);
				if (got.qpend !== want.qpend)
					$display("%0t: region_pending exp %0d got %0d", $time, want.qpend,
						got.qpend);
				if (got.stamp !== want.stamp)
					$display("%0t: region_stamp exp %h got %h", $time, want.stamp, got.stamp);
				if (got !== want) errors++;
			end
		end
		if (recv_gap > 0) begin
			m_tready <= 0;
			recv_gap <= recv_gap - 1;
		end else begin
			m_tready <= 1;
			if (m_tvalid && m_tready) recv_gap <= pick_gap();
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (request_q.size() == 0 && grant_q.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic apb_write(input logic idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == rrso_pkg::ADDR_REGION_COUNT) region_cnt = val[6:0];
		else starve_limit = val;
	endtask

	task automatic add_request(input logic [2:0] rq, input logic [5:0] rg,
		input logic [5:0] cur, input logic [63:0] t);
		request_t r;
		r.req = rq;
		r.region = rg;
		r.cursor = cur;
		r.now_time = t;
		request_q.push_back(r);
	endtask

	task automatic drain();
		wait (request_q.size() == 0);
		while (grant_q.size() != 0 || s_tvalid) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		logic [63:0] clock_ns;
		int n;
		logic [2:0] rq;
		for (int i = 0; i < MAXR; i++) begin
			pend_flag[i] = 0;
			first_dirty[i] = 0;
		end
		pend_total = 0;
		region_cnt = 64;
		starve_limit = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: enqueue at time zero, extremes, future stamp, unused codes
		add_request(rrso_pkg::REQ_ENQUEUE, 0, 0, 64'd0);
		add_request(rrso_pkg::REQ_ENQUEUE, 63, 0, '1);
		add_request(rrso_pkg::REQ_ENQUEUE, 63, 0, 64'd5);
		add_request(rrso_pkg::REQ_QUERY, 0, 0, 0);
		add_request(rrso_pkg::REQ_QUERY, 63, 0, 0);
		add_request(rrso_pkg::REQ_TAKE, 0, 63, 64'd7);
		add_request(rrso_pkg::REQ_TAKE, 0, 63, 64'd7);
		add_request(rrso_pkg::REQ_TAKE, 0, 63, 64'd7);
		add_request(rrso_pkg::REQ_ENQUEUE, 10, 0, 64'd100);
		add_request(rrso_pkg::REQ_FORGET, 10, 0, 0);
		add_request(rrso_pkg::REQ_QUERY, 10, 0, 0);
		add_request(3'd5, 1, 2, '1);
		add_request(3'd6, 42, 21, 0);
		add_request(3'd7, 63, 63, '1);
		add_request(rrso_pkg::REQ_CLEAR, 0, 0, 0);
		drain();

		// starvation override, stamp in the future, lowered count
		apb_write(rrso_pkg::ADDR_STARVE_LIMIT, 64'd50);
		add_request(rrso_pkg::REQ_ENQUEUE, 5, 0, 64'd10);
		add_request(rrso_pkg::REQ_ENQUEUE, 2, 0, 64'd20);
		add_request(rrso_pkg::REQ_TAKE, 0, 1, 64'd30);
		add_request(rrso_pkg::REQ_TAKE, 0, 1, 64'd100);
		add_request(rrso_pkg::REQ_ENQUEUE, 40, 0, 64'd1000);
		add_request(rrso_pkg::REQ_TAKE, 0, 0, 64'd500);
		drain();
		apb_write(rrso_pkg::ADDR_REGION_COUNT, 7'd0);
		add_request(rrso_pkg::REQ_ENQUEUE, 0, 0, 64'd3);
		add_request(rrso_pkg::REQ_TAKE, 0, 63, 64'd3);
		add_request(rrso_pkg::REQ_QUERY, 40, 0, 0);
		add_request(rrso_pkg::REQ_FORGET, 40, 0, 0);
		add_request(rrso_pkg::REQ_TAKE, 0, 0, '1);
		drain();
		apb_write(rrso_pkg::ADDR_REGION_COUNT, 7'd127);
		apb_write(rrso_pkg::ADDR_STARVE_LIMIT, '1);
		add_request(rrso_pkg::REQ_TAKE, 0, 0, '1);
		add_request(rrso_pkg::REQ_CLEAR, 0, 0, 0);
		drain();

		// random phases across settings
		clock_ns = 64'd1;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: apb_write(rrso_pkg::ADDR_REGION_COUNT, $urandom_range(1, 8));
				1: apb_write(rrso_pkg::ADDR_REGION_COUNT, 64);
				2: apb_write(rrso_pkg::ADDR_REGION_COUNT, $urandom_range(0, 127));
				default: apb_write(rrso_pkg::ADDR_REGION_COUNT, $urandom_range(1, 64));
			endcase
			case (ph % 3)
				0: apb_write(rrso_pkg::ADDR_STARVE_LIMIT, 0);
				1: apb_write(rrso_pkg::ADDR_STARVE_LIMIT, $urandom_range(1, 200));
				default: apb_write(rrso_pkg::ADDR_STARVE_LIMIT, {$urandom, $urandom});
			endcase
			n = active_regions();
			for (int k = 0; k < 100; k++) begin
				clock_ns += $urandom_range(0, 40);
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7: rq = rrso_pkg::REQ_ENQUEUE;
					8, 9, 10, 11, 12, 13: rq = rrso_pkg::REQ_TAKE;
					14, 15: rq = rrso_pkg::REQ_FORGET;
					16: rq = ($urandom_range(0, 3) == 0) ? rrso_pkg::REQ_CLEAR :
						rrso_pkg::REQ_QUERY;
					17, 18: rq = rrso_pkg::REQ_QUERY;
					default: rq = $urandom_range(0, 7);
				endcase
				if ($urandom_range(0, 30) == 0)
					add_request(rq, $urandom, $urandom, {$urandom, $urandom});
				else
					add_request(rq,
						($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, n - 1),
						$urandom, ($urandom_range(0, 15) == 0) ? 64'd0 : clock_ns);
			end
			drain();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
